/* sv/sbda_pkg.sv */
// Shared constants and control types for the signed binary to decimal ASCII core.
`timescale 1ns / 1ps

package sbda_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam int         BCD_W      = 4;

   // commands from the sequencer to the double-dabble unit
   typedef struct packed {
      logic load;    // take a new value and start converting
      logic shift;   // drop the top digit, bring the next one up
   } conv_ctrl_type;

   typedef struct packed {
      logic busy;    // conversion still running
   } conv_stat_type;

endpackage

/* sv/sbda_dabble.sv */
// Bit-serial double-dabble unit: magnitude in, BCD digits out, one bit per cycle.
`timescale 1ns / 1ps

module sbda_dabble
   import sbda_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int DIGITS      = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  conv_ctrl_type          ctrl,
   input  logic [VALUE_WIDTH-1:0] value,
   output conv_stat_type          stat,
   output logic [BCD_W-1:0]       top_digit
);

   localparam int BCD_TOTAL = DIGITS * BCD_W;
   localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_TOTAL-1:0]   bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] magnitude;

   // two's complement magnitude; the most negative value maps to itself, read unsigned
   assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

   // add-3 correction on every digit that would overflow when doubled
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*BCD_W +: BCD_W] >= 4'd5) begin
            bcd_adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W] + 4'd3;
         end else begin
            bcd_adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      priority if (ctrl.load) begin
         bin_in = magnitude;
         bcd_in = '0;
         cnt_in = CNT_W'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_TOTAL-2:0], bin_ff[VALUE_WIDTH-1]};
         cnt_in = cnt_ff - 1'b1;
      end else if (ctrl.shift) begin
         bcd_in = {bcd_ff[BCD_TOTAL-BCD_W-1:0], {BCD_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign top_digit = bcd_ff[BCD_TOTAL-1 -: BCD_W];

endmodule

/* sv/signed_binary_to_decimal_ascii_core.sv */
// Top level: signed integer in, decimal ASCII characters out, most significant first.
//
//   channel | dir | tdata                      | tuser | tlast
//   req_    | in  | value [VALUE_WIDTH-1:0]    | -     | -
//   rsp_    | out | character [7:0]            | -     | last character of the number
//
// One word in at a time; req_tready is high only while idle. After acceptance the
// double-dabble unit converts the magnitude one bit per cycle and the sequencer waits for
// it to finish, then leading zeros are dropped one digit per cycle (up to DIGITS-1) and the
// sequencer decides on the sign; the sign, if any, and the digits then leave one per cycle
// while rsp_tready takes them; a full output register is held until taken. A new word is
// taken as soon as the last character sits in the output register. Reset is synchronous
// and clears the sequencer and the output valid.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_core
   import sbda_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,   // value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,   // character
   output logic                                  rsp_tlast
);

   // decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10 2)
   localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int REM_W  = $clog2(DIGITS + 1);

   typedef enum logic [2:0] {
      IDLE,
      CONV,
      SKIP,
      SIGN,
      EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             neg_ff, neg_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic             slot_free;

   conv_ctrl_type    ctrl;
   conv_stat_type    stat;
   logic [BCD_W-1:0] digit;

   sbda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .value     (req_tdata[VALUE_WIDTH-1:0]),
      .stat      (stat),
      .top_digit (digit)
   );

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      valid_in   = valid_ff && !rsp_tready;
      char_in    = char_ff;
      last_in    = last_ff;
      ctrl       = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               neg_in    = req_tdata[VALUE_WIDTH-1];
               rem_in    = REM_W'(DIGITS);
               state_in  = CONV;
            end
         end
         CONV: begin
            if (!stat.busy) begin
               state_in = SKIP;
            end
         end
         SKIP: begin
            // keep at least one digit so zero prints as '0'
            if (digit == '0 && rem_ff != REM_W'(1)) begin
               ctrl.shift = 1'b1;
               rem_in     = rem_ff - 1'b1;
            end else begin
               state_in = neg_ff ? SIGN : EMIT;
            end
         end
         SIGN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (slot_free) begin
               valid_in   = 1'b1;
               char_in    = CHAR_ZERO | {4'b0000, digit};
               last_in    = (rem_ff == REM_W'(1));
               ctrl.shift = 1'b1;
               rem_in     = rem_ff - 1'b1;
               if (rem_ff == REM_W'(1)) begin
                  state_in = IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule
